[hdl/fepq_pkg.sv]
// Shared types and constants for the FIFO row/byte quota eviction block.
package fepq_pkg;

   localparam int BLOCK_W   = 32;  // row and byte count of one stored block
   localparam int LIMIT_W   = 40;  // limit registers and reported totals
   localparam int OUT_CNT_W = 9;   // reported block counts
   localparam int CSR_IDX_W = 2;

   typedef enum logic [1:0] {
      ACT_STAGE  = 2'd0,
      ACT_COMMIT = 2'd1,
      ACT_TRIM   = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BYTE_UPPER = 2'd0,
      REG_ROW_UPPER  = 2'd1,
      REG_BYTE_LOWER = 2'd2,
      REG_ROW_LOWER  = 2'd3
   } csr_reg_type;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic [LIMIT_W-1:0] byte_upper;
      logic [LIMIT_W-1:0] row_upper;
      logic [LIMIT_W-1:0] byte_lower;
      logic [LIMIT_W-1:0] row_lower;
   } limits_type;

   typedef struct packed {
      logic [BLOCK_W-1:0] rows;
      logic [BLOCK_W-1:0] bytes;
   } entry_type;

endpackage

[hdl/fepq_req_if.sv]
// Request channel: one action with the staged block's row and byte counts.
interface fepq_req_if import fepq_pkg::*; ();
   logic               valid;
   logic               ready;
   action_type         action;
   logic [BLOCK_W-1:0] block_rows;
   logic [BLOCK_W-1:0] block_bytes;

   modport source (output valid, action, block_rows, block_bytes, input ready);
   modport sink   (input valid, action, block_rows, block_bytes, output ready);
endinterface

[hdl/fepq_rsp_if.sv]
// Response channel: status, eviction count and committed totals after a request.
interface fepq_rsp_if import fepq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 status;
   logic [OUT_CNT_W-1:0] evicted_blocks;
   logic [OUT_CNT_W-1:0] stored_blocks;
   logic [LIMIT_W-1:0]   total_rows;
   logic [LIMIT_W-1:0]   total_bytes;

   modport source (output valid, status, evicted_blocks, stored_blocks, total_rows,
                   total_bytes, input ready);
   modport sink   (input valid, status, evicted_blocks, stored_blocks, total_rows,
                   total_bytes, output ready);
endinterface

[hdl/fifo_eviction_by_row_byte_quota_unit.sv]
// Top level: FIFO block store with row/byte quota eviction and its sequencer.
//
// Usage: requests arrive on req_chan (valid/ready). action 0 stages a block
// (block_rows, block_bytes) into the pending batch, 1 commits the batch after
// evicting the oldest blocks while a total exceeds its nonzero upper limit and
// no lower limit is crossed, 2 trims committed blocks alike, 3 clears the store.
// Every request yields exactly one response on rsp_chan with status, the
// number of evicted blocks and the committed count and totals afterwards.
// Limits are to be written by the user on the csr_ port while no request is in
// flight; the block does not enforce this. Stage and clear pass through EXEC
// and DONE before the response register is loaded. Commit and trim pass
// through EXEC, EVICT and DONE; the eviction walk reads one ring entry per cycle
// from the block memory, whose read address always follows the next oldest
// position. A new request is taken in the cycle the previous response is
// loaded, so requests are handled one at a time.
// Reset (synchronous, active high) empties the store and zeroes the limits;
// the ring memory is not cleared, since only written entries are ever read.
// If the response is stalled, the response register holds it; the next
// request is still accepted and processed and waits before its response.
module fifo_eviction_by_row_byte_quota_unit import fepq_pkg::*; #(
   parameter int STORE_DEPTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   fepq_req_if.sink             req_chan,
   fepq_rsp_if.source           rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LIMIT_W-1:0]   csr_wdata
);

   localparam int IDX_W = $clog2(STORE_DEPTH);
   localparam int CNT_W = $clog2(STORE_DEPTH + 1);
   // sum of up to STORE_DEPTH block counts fits here
   localparam int TOT_W = BLOCK_W + IDX_W;
   localparam int CMP_W = (TOT_W > LIMIT_W) ? TOT_W : LIMIT_W;
   localparam logic [IDX_W-1:0] LAST_POS  = IDX_W'(STORE_DEPTH - 1);
   localparam logic [CNT_W:0]   DEPTH_SUM = (CNT_W + 1)'(STORE_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_EVICT,
      ST_DONE
   } state_type;

   limits_type limits;
   entry_type  rd_data;
   entry_type  wr_data;
   logic       wr_en;
   logic [IDX_W-1:0] wr_addr;

   // control state
   state_type        state_ff,  state_in;
   logic [IDX_W-1:0] oldest_ff, oldest_in;
   logic [CNT_W-1:0] ccount_ff, ccount_in;
   logic [CNT_W-1:0] pcount_ff, pcount_in;
   logic [TOT_W-1:0] crows_ff,  crows_in;
   logic [TOT_W-1:0] cbytes_ff, cbytes_in;
   logic [TOT_W-1:0] prows_ff,  prows_in;
   logic [TOT_W-1:0] pbytes_ff, pbytes_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // request and working payload
   action_type         act_ff,    act_in;
   logic [BLOCK_W-1:0] rows_ff,   rows_in;
   logic [BLOCK_W-1:0] bytes_ff,  bytes_in;
   logic [TOT_W-1:0]   wrows_ff,  wrows_in;
   logic [TOT_W-1:0]   wbytes_ff, wbytes_in;
   logic [CNT_W-1:0]   evict_ff,  evict_in;
   logic               status_ff, status_in;

   // response register
   logic                 rsp_status_ff,  rsp_status_in;
   logic [OUT_CNT_W-1:0] rsp_evicted_ff, rsp_evicted_in;
   logic [OUT_CNT_W-1:0] rsp_stored_ff,  rsp_stored_in;
   logic [LIMIT_W-1:0]   rsp_rows_ff,    rsp_rows_in;
   logic [LIMIT_W-1:0]   rsp_bytes_ff,   rsp_bytes_in;

   logic             out_free;
   logic             req_ready;
   logic             accept;
   logic [CNT_W:0]   used;
   logic             full;
   logic [CNT_W:0]   wr_sum;
   logic [CNT_W:0]   wr_pos;
   logic             over;
   logic [TOT_W-1:0] ent_rows;
   logic [TOT_W-1:0] ent_bytes;
   logic [TOT_W-1:0] next_rows;
   logic [TOT_W-1:0] next_bytes;
   logic             floor_hit;
   logic             evict_ok;
   logic [IDX_W-1:0] oldest_next;

   fepq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .limits    (limits)
   );

   // read address tracks the next oldest entry so its data is ready next cycle
   fepq_store #(.DEPTH(STORE_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (oldest_in),
      .rd_data (rd_data)
   );

   // handshake
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_DONE) && out_free);
   assign accept    = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;

   // occupancy and append position (ring wrap by one compare/subtract)
   assign used    = {1'b0, ccount_ff} + {1'b0, pcount_ff};
   assign full    = used >= DEPTH_SUM;
   assign wr_sum  = (CNT_W + 1)'(oldest_ff) + used;
   assign wr_pos  = (wr_sum >= DEPTH_SUM) ? (wr_sum - DEPTH_SUM) : wr_sum;
   assign wr_addr = wr_pos[IDX_W-1:0];
   assign wr_data = '{rows: rows_ff, bytes: bytes_ff};

   // eviction step against the oldest entry
   assign over = (ccount_ff != '0) &&
                 (((limits.byte_upper != '0) &&
                   (CMP_W'(wbytes_ff) > CMP_W'(limits.byte_upper))) ||
                  ((limits.row_upper != '0) &&
                   (CMP_W'(wrows_ff) > CMP_W'(limits.row_upper))));
   assign ent_rows   = TOT_W'(rd_data.rows);
   assign ent_bytes  = TOT_W'(rd_data.bytes);
   assign next_rows  = (wrows_ff >= ent_rows) ? (wrows_ff - ent_rows) : '0;
   assign next_bytes = (wbytes_ff >= ent_bytes) ? (wbytes_ff - ent_bytes) : '0;
   assign floor_hit  = (CMP_W'(next_bytes) < CMP_W'(limits.byte_lower)) ||
                       (CMP_W'(next_rows) < CMP_W'(limits.row_lower));
   assign evict_ok   = over && !floor_hit;
   assign oldest_next = (oldest_ff == LAST_POS) ? '0 : (oldest_ff + 1'b1);

   always_comb begin
      state_in     = state_ff;
      oldest_in    = oldest_ff;
      ccount_in    = ccount_ff;
      pcount_in    = pcount_ff;
      crows_in     = crows_ff;
      cbytes_in    = cbytes_ff;
      prows_in     = prows_ff;
      pbytes_in    = pbytes_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      act_in       = act_ff;
      rows_in      = rows_ff;
      bytes_in     = bytes_ff;
      wrows_in     = wrows_ff;
      wbytes_in    = wbytes_ff;
      evict_in     = evict_ff;
      status_in    = status_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_stored_in  = rsp_stored_ff;
      rsp_rows_in    = rsp_rows_ff;
      rsp_bytes_in   = rsp_bytes_ff;
      wr_en        = 1'b0;

      if (accept) begin
         act_in   = req_chan.action;
         rows_in  = req_chan.block_rows;
         bytes_in = req_chan.block_bytes;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            status_in = STATUS_OK;
            evict_in  = '0;
            unique case (act_ff)
               ACT_STAGE: begin
                  if (full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     wr_en     = 1'b1;
                     pcount_in = pcount_ff + 1'b1;
                     prows_in  = prows_ff + TOT_W'(rows_ff);
                     pbytes_in = pbytes_ff + TOT_W'(bytes_ff);
                  end
                  state_in = ST_DONE;
               end
               ACT_COMMIT: begin
                  wrows_in  = crows_ff + prows_ff;
                  wbytes_in = cbytes_ff + pbytes_ff;
                  state_in  = ST_EVICT;
               end
               ACT_TRIM: begin
                  wrows_in  = crows_ff;
                  wbytes_in = cbytes_ff;
                  state_in  = ST_EVICT;
               end
               ACT_CLEAR: begin
                  evict_in  = ccount_ff;
                  oldest_in = '0;
                  ccount_in = '0;
                  pcount_in = '0;
                  crows_in  = '0;
                  cbytes_in = '0;
                  prows_in  = '0;
                  pbytes_in = '0;
                  state_in  = ST_DONE;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_EVICT: begin
            if (evict_ok) begin
               wrows_in  = next_rows;
               wbytes_in = next_bytes;
               oldest_in = oldest_next;
               ccount_in = ccount_ff - 1'b1;
               evict_in  = evict_ff + 1'b1;
            end else begin
               crows_in  = wrows_ff;
               cbytes_in = wbytes_ff;
               if (act_ff == ACT_COMMIT) begin
                  ccount_in = ccount_ff + pcount_ff;
                  pcount_in = '0;
                  prows_in  = '0;
                  pbytes_in = '0;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_evicted_in = OUT_CNT_W'(evict_ff);
               rsp_stored_in  = OUT_CNT_W'(ccount_ff);
               rsp_rows_in    = LIMIT_W'(crows_ff);
               rsp_bytes_in   = LIMIT_W'(cbytes_ff);
               state_in       = accept ? ST_EXEC : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         oldest_ff    <= '0;
         ccount_ff    <= '0;
         pcount_ff    <= '0;
         crows_ff     <= '0;
         cbytes_ff    <= '0;
         prows_ff     <= '0;
         pbytes_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         ccount_ff    <= ccount_in;
         pcount_ff    <= pcount_in;
         crows_ff     <= crows_in;
         cbytes_ff    <= cbytes_in;
         prows_ff     <= prows_in;
         pbytes_ff    <= pbytes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff         <= act_in;
      rows_ff        <= rows_in;
      bytes_ff       <= bytes_in;
      wrows_ff       <= wrows_in;
      wbytes_ff      <= wbytes_in;
      evict_ff       <= evict_in;
      status_ff      <= status_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_stored_ff  <= rsp_stored_in;
      rsp_rows_ff    <= rsp_rows_in;
      rsp_bytes_ff   <= rsp_bytes_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.evicted_blocks = rsp_evicted_ff;
   assign rsp_chan.stored_blocks  = rsp_stored_ff;
   assign rsp_chan.total_rows     = rsp_rows_ff;
   assign rsp_chan.total_bytes    = rsp_bytes_ff;

   // committed plus pending blocks never exceed the ring
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      used <= DEPTH_SUM)
      else $error("ring occupancy beyond store depth");

   // an accepted request always starts execution in the next cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("accepted request not executed");

   // a refused stage leaves the pending batch untouched
   a_refused_stage: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) && (act_ff == ACT_STAGE) && full
      |=> $stable(pcount_ff) && $stable(prows_ff) && $stable(pbytes_ff))
      else $error("refused stage changed pending batch");

   // each eviction step removes exactly one block and advances the head
   a_evict_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVICT) && evict_ok
      |=> (ccount_ff == ($past(ccount_ff) - 1'b1)) && (oldest_ff != $past(oldest_ff)))
      else $error("eviction step did not remove one block");

endmodule

[hdl/fepq_csr.sv]
// Limit registers written through the plain CSR write port.
module fepq_csr import fepq_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LIMIT_W-1:0]   csr_wdata,
   output limits_type           limits
);

   limits_type limits_ff;
   limits_type limits_in;

   always_comb begin
      limits_in = limits_ff;
      if (csr_we) begin
         unique case (csr_reg_type'(csr_index))
            REG_BYTE_UPPER: limits_in.byte_upper = csr_wdata;
            REG_ROW_UPPER:  limits_in.row_upper  = csr_wdata;
            REG_BYTE_LOWER: limits_in.byte_lower = csr_wdata;
            REG_ROW_LOWER:  limits_in.row_lower  = csr_wdata;
            default:        limits_in = limits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff <= '0;
      end else begin
         limits_ff <= limits_in;
      end
   end

   assign limits = limits_ff;

endmodule

[hdl/fepq_store.sv]
// Block ring memory: one write port, one read port with registered read data.
module fepq_store import fepq_pkg::*; #(
   parameter  int DEPTH = 256,
   localparam int IDX_W = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type store_mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
